[design/wmd_pkg.sv]
// Shared types and constants for the waveform min/max decimator.
// No dependencies; every other design file imports this package.
package wmd_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int COORD_BITS         = 12;
    localparam int STEP_FRACTION_BITS = 24;
    localparam int STEP_BITS          = 32;
    localparam int MIDDLE_BITS        = 11;
    localparam int ACC_BITS           = COORD_BITS + STEP_FRACTION_BITS;
    localparam int CFG_DATA_BITS      = 32;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_STEP  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIDDLE_LINE = 1'b1;

    localparam logic [STEP_BITS-1:0]   PIXEL_STEP_RESET  = STEP_BITS'(1) << STEP_FRACTION_BITS;
    localparam logic [MIDDLE_BITS-1:0] MIDDLE_LINE_RESET = MIDDLE_BITS'(64);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COORD_BITS-1:0]         coord_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int      COORD_MAX  = (1 << COORD_BITS) - 1;

    // Row mapping: y = floor(m * (10*half - 9*s) / (10*half)), half = 2^(SAMPLE_BITS-1).
    // The quotient by half is a shift; the quotient by ten is a reciprocal multiply,
    // exact because m * (10*half - 9*s) / half stays below 2^16.
    localparam int ROW_U_BITS      = SAMPLE_BITS + 4;
    localparam int ROW_NUM_BITS    = MIDDLE_BITS + ROW_U_BITS;
    localparam int ROW_Q_BITS      = 16;
    localparam int ROW_RECIP_BITS  = 16;
    localparam logic [ROW_RECIP_BITS-1:0] ROW_RECIP = 16'd52429;
    localparam int ROW_RECIP_SHIFT = 19;
    localparam int ROW_PROD_BITS   = ROW_Q_BITS + ROW_RECIP_BITS;
    localparam int ROW_Y_BITS      = ROW_PROD_BITS - ROW_RECIP_SHIFT;

    typedef struct packed {
        sample_t sample;
        logic    first_of_buffer;
    } sample_item_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   last_point;
    } point_item_t;

    // One column change: the endpoints to draw
    typedef struct packed {
        coord_t  xl;
        coord_t  xr;
        logic    tall;
        sample_t col_min;
        sample_t col_max;
        sample_t prev;
        sample_t cur;
    } seg_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[design/waveform_minmax_decimator.sv]
// Flow: a sample that changes the pixel column pushes one command into the queue; its
// endpoints pass the select, u, m*u and q*recip registers and the output register to
// point_valid, one per cycle while point_stall is low (2 or 4 endpoints per sample).
// Throughput: one sample per cycle while the command queue has room; the single-point
// output register takes one endpoint at a time, so it limits the rate of column changes.
// Reset: asynchronous, active low; tracking state, queue and pipeline clear at once.
module waveform_minmax_decimator #(
    parameter int QUEUE_DEPTH = wmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  wmd_pkg::sample_item_t                sample_item,
    output logic                                 point_valid,
    input  logic                                 point_stall,
    output wmd_pkg::point_item_t                 point_item,
    input  logic                                 cfg_we,
    input  logic [wmd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wmd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import wmd_pkg::*;

    logic [STEP_BITS-1:0]   pixel_step_reg;
    logic [MIDDLE_BITS-1:0] middle_line_reg;

    logic                           push, pop;
    seg_cmd_t                       push_cmd, head;
    queue_status_t                  q_status;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_step_reg  <= PIXEL_STEP_RESET;
            middle_line_reg <= MIDDLE_LINE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_STEP:  pixel_step_reg  <= cfg_data[STEP_BITS-1:0];
                REG_MIDDLE_LINE: middle_line_reg <= cfg_data[MIDDLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    wmd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .pixel_step   (pixel_step_reg),
        .q_status     (q_status),
        .push         (push),
        .cmd          (push_cmd)
    );

    wmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status),
        .count    (q_count)
    );

    wmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .middle_line (middle_line_reg),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_item  (point_item)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_count != '0))
        else $error("queue popped while empty");

    a_prime_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall && sample_item.first_of_buffer) |-> !push)
        else $error("buffer start produced a segment");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_count) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("queue count lost a transfer");
`endif

endmodule

[design/wmd_front.sv]
// Front end: accepts samples, tracks pixel position and column min/max,
// and queues a segment command whenever the pixel column changes. Uses wmd_pkg.
module wmd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  wmd_pkg::sample_item_t                sample_item,
    input  logic [wmd_pkg::STEP_BITS-1:0]        pixel_step,
    input  wmd_pkg::queue_status_t               q_status,
    output logic                                 push,
    output wmd_pkg::seg_cmd_t                    cmd
);
    import wmd_pkg::*;

    localparam logic [1:0] COUNT_SAT = 2'd2;

    sample_t             prev_sample_reg, prev_sample_next;
    logic [ACC_BITS-1:0] acc_reg, acc_next, acc_sum;
    logic [1:0]          cnt_reg, cnt_next, cnt_inc;
    sample_t             min_reg, min_next, min_a, min_b;
    sample_t             max_reg, max_next, max_a, max_b;
    logic                primed_reg, primed_next;
    logic                accept, prime;
    sample_t             s;
    coord_t              xl, xr;

    assign sample_stall = q_status.full;
    assign accept       = sample_valid && !q_status.full;
    assign s            = sample_item.sample;
    assign prime        = sample_item.first_of_buffer || !primed_reg;

    assign acc_sum = acc_reg + ACC_BITS'(pixel_step);
    assign xl      = acc_reg[ACC_BITS-1 -: COORD_BITS];
    assign xr      = acc_sum[ACC_BITS-1 -: COORD_BITS];

    assign min_a   = (prev_sample_reg < min_reg) ? prev_sample_reg : min_reg;
    assign min_b   = (s < min_a) ? s : min_a;
    assign max_a   = (prev_sample_reg > max_reg) ? prev_sample_reg : max_reg;
    assign max_b   = (s > max_a) ? s : max_a;
    assign cnt_inc = (cnt_reg == COUNT_SAT) ? COUNT_SAT : cnt_reg + 2'd1;

    always_comb
    begin
        prev_sample_next = prev_sample_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        primed_next      = primed_reg;
        push             = 1'b0;

        cmd.xl      = xl;
        cmd.xr      = xr;
        cmd.tall    = (cnt_inc == COUNT_SAT);
        cmd.col_min = min_b;
        cmd.col_max = max_b;
        cmd.prev    = prev_sample_reg;
        cmd.cur     = s;

        if (accept)
        begin
            prev_sample_next = s;
            if (prime)
            begin
                acc_next    = '0;
                cnt_next    = '0;
                min_next    = SAMPLE_MAX;
                max_next    = SAMPLE_MIN;
                primed_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum;
                if (xl != xr)
                begin
                    push     = 1'b1;
                    cnt_next = '0;
                    min_next = SAMPLE_MAX;
                    max_next = SAMPLE_MIN;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    min_next = min_b;
                    max_next = max_b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            min_reg         <= SAMPLE_MAX;
            max_reg         <= SAMPLE_MIN;
            primed_reg      <= 1'b0;
        end
        else
        begin
            prev_sample_reg <= prev_sample_next;
            acc_reg         <= acc_next;
            cnt_reg         <= cnt_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            primed_reg      <= primed_next;
        end
    end

endmodule

[design/wmd_queue.sv]
// Short command queue between the front end and the endpoint back end.
// Uses wmd_pkg for the command and status types.
module wmd_queue #(
    parameter int DEPTH = wmd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  wmd_pkg::seg_cmd_t             push_cmd,
    input  logic                          pop,
    output wmd_pkg::seg_cmd_t             head,
    output wmd_pkg::queue_status_t        status,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import wmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    seg_cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign count        = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/wmd_back.sv]
// Back end: walks the endpoints of each queued command, one per cycle unless
// point_stall holds the output, maps samples to rows in a four-stage pipeline
// and holds the output register. Uses wmd_pkg.
module wmd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wmd_pkg::seg_cmd_t                head,
    input  wmd_pkg::queue_status_t           q_status,
    output logic                             pop,
    input  logic [wmd_pkg::MIDDLE_BITS-1:0]  middle_line,
    output logic                             point_valid,
    input  logic                             point_stall,
    output wmd_pkg::point_item_t             point_item
);
    import wmd_pkg::*;

    localparam logic signed [ROW_U_BITS:0] TEN_HALF = (ROW_U_BITS + 1)'(10) << (SAMPLE_BITS - 1);

    logic                 adv, issue, last_sel;
    logic [1:0]           idx_reg, idx_next;
    sample_t              samp_sel;
    coord_t               x_sel;

    // pipeline: select -> u -> m*u -> q*recip -> output
    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    coord_t               x0_reg, x1_reg, x2_reg, x3_reg;
    logic                 l0_reg, l1_reg, l2_reg, l3_reg;
    sample_t              samp0_reg;
    logic [ROW_U_BITS-1:0]    u1_reg;
    logic [ROW_NUM_BITS-1:0]  num2_reg;
    logic [ROW_PROD_BITS-1:0] prod3_reg;

    logic signed [ROW_U_BITS:0] sx, u_wide;
    logic [ROW_Q_BITS-1:0]      q;
    logic [ROW_Y_BITS-1:0]      y_wide;
    coord_t                     y_sat;

    logic                 out_valid_reg;
    point_item_t          out_item_reg;

    assign adv   = !out_valid_reg || !point_stall;
    assign issue = adv && !q_status.empty;

    always_comb
    begin
        samp_sel = head.prev;
        last_sel = 1'b0;
        if (head.tall)
        begin
            case (idx_reg)
                2'd0:    samp_sel = head.col_min;
                2'd1:    samp_sel = head.col_max;
                2'd2:    samp_sel = head.prev;
                default:
                begin
                    samp_sel = head.cur;
                    last_sel = 1'b1;
                end
            endcase
        end
        else if (idx_reg != 2'd0)
        begin
            samp_sel = head.cur;
            last_sel = 1'b1;
        end
        x_sel    = last_sel ? head.xr : head.xl;
        pop      = issue && last_sel;
        idx_next = idx_reg;
        if (issue)
            idx_next = last_sel ? 2'd0 : idx_reg + 2'd1;
    end

    assign sx     = (ROW_U_BITS + 1)'(samp0_reg);
    assign u_wide = TEN_HALF - (sx <<< 3) - sx;
    assign q      = num2_reg[SAMPLE_BITS-1 +: ROW_Q_BITS];
    assign y_wide = prod3_reg[ROW_PROD_BITS-1:ROW_RECIP_SHIFT];
    assign y_sat  = (32'(y_wide) > 32'(COORD_MAX)) ? '1 : COORD_BITS'(y_wide);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            samp0_reg <= samp_sel;
            x0_reg    <= x_sel;
            l0_reg    <= last_sel;
            u1_reg    <= u_wide[ROW_U_BITS-1:0];
            x1_reg    <= x0_reg;
            l1_reg    <= l0_reg;
            num2_reg  <= ROW_NUM_BITS'(middle_line) * ROW_NUM_BITS'(u1_reg);
            x2_reg    <= x1_reg;
            l2_reg    <= l1_reg;
            prod3_reg <= ROW_PROD_BITS'(q) * ROW_PROD_BITS'(ROW_RECIP);
            x3_reg    <= x2_reg;
            l3_reg    <= l2_reg;
            out_item_reg.point_x    <= x3_reg;
            out_item_reg.point_y    <= y_sat;
            out_item_reg.last_point <= l3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (adv)
            begin
                v0_reg        <= issue;
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    assign point_valid = out_valid_reg;
    assign point_item  = out_item_reg;

endmodule

[tb/waveform_minmax_decimator_checker.sv]
`timescale 1ns / 100ps
// Endpoint checker for the waveform min/max decimator: watches the sample, point and
// register ports, predicts every endpoint and compares it in order.
// Depends on wmd_pkg for the payload types and register indexes.
module waveform_minmax_decimator_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    input  logic                               sample_stall,
    input  wmd_pkg::sample_item_t              sample_item,
    input  logic                               point_valid,
    input  logic                               point_stall,
    input  wmd_pkg::point_item_t               point_item,
    input  logic                               cfg_we,
    input  logic [wmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 fail_count,
    output int                                 endpoints_due,
    output int                                 samples_seen,
    output int                                 endpoints_seen
);
    import wmd_pkg::*;

    logic [STEP_BITS-1:0]   step_cfg;
    logic [MIDDLE_BITS-1:0] middle_cfg;

    sample_t             prior_sample;
    logic [ACC_BITS-1:0] column_pos;
    logic [1:0]          column_hits;
    sample_t             column_low;
    sample_t             column_high;
    logic                buffer_open;

    point_item_t pending_endpoints[$];

    initial begin
        fail_count     = 0;
        endpoints_due  = 0;
        samples_seen   = 0;
        endpoints_seen = 0;
    end

    // y = floor(m - s * 0.9 * m / half), exact; numerator never goes negative
    function automatic coord_t row_for(sample_t s);
        longint den;
        longint num;
        longint y;
        den = 10 * (longint'(1) << (SAMPLE_BITS - 1));
        num = longint'(middle_cfg) * den - longint'(s) * 9 * longint'(middle_cfg);
        y = num / den;
        if (y > COORD_MAX)
            y = COORD_MAX;
        return coord_t'(y);
    endfunction

    function automatic void add_endpoint(coord_t x, sample_t v, logic last);
        point_item_t ep;
        ep.point_x    = x;
        ep.point_y    = row_for(v);
        ep.last_point = last;
        pending_endpoints = {pending_endpoints, ep};
    endfunction

    function automatic void clear_column();
        column_hits = '0;
        column_low  = SAMPLE_MAX;
        column_high = SAMPLE_MIN;
    endfunction

    function automatic void trace_sample(sample_item_t item);
        sample_t s;
        sample_t left;
        coord_t  xl;
        coord_t  xr;
        s = item.sample;
        // buffer start, or anything before the first buffer start, only primes
        if (item.first_of_buffer || !buffer_open) begin
            prior_sample = s;
            column_pos   = '0;
            clear_column();
            buffer_open  = 1'b1;
            return;
        end
        left = prior_sample;
        xl = column_pos[ACC_BITS-1 -: COORD_BITS];
        column_pos = column_pos + ACC_BITS'(step_cfg);
        xr = column_pos[ACC_BITS-1 -: COORD_BITS];
        if (left < column_low)  column_low  = left;
        if (left > column_high) column_high = left;
        if (s < column_low)     column_low  = s;
        if (s > column_high)    column_high = s;
        if (column_hits < 2'd2)
            column_hits = column_hits + 2'd1;
        prior_sample = s;
        if (xl == xr)
            return;
        if (column_hits > 2'd1) begin
            add_endpoint(xl, column_low, 1'b0);
            add_endpoint(xl, column_high, 1'b0);
        end
        add_endpoint(xl, left, 1'b0);
        add_endpoint(xr, s, 1'b1);
        clear_column();
    endfunction

    function automatic void check_endpoint(point_item_t got);
        point_item_t want;
        endpoints_seen++;
        if (pending_endpoints.size() == 0) begin
            $error("endpoint with none pending: x=%0d y=%0d last=%0d",
                   got.point_x, got.point_y, got.last_point);
            fail_count++;
            return;
        end
        want = pending_endpoints.pop_front();
        if (got.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
            fail_count++;
        end
        if (got.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
            fail_count++;
        end
        if (got.last_point !== want.last_point) begin
            $error("last_point: expected %0d, got %0d", want.last_point, got.last_point);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_cfg     = PIXEL_STEP_RESET;
            middle_cfg   = MIDDLE_LINE_RESET;
            prior_sample = '0;
            column_pos   = '0;
            clear_column();
            buffer_open  = 1'b0;
            pending_endpoints.delete();
        end
        else begin
            // an endpoint leaving now came from an earlier sample, so check it first
            if (point_valid && !point_stall)
                check_endpoint(point_item);
            if (sample_valid && !sample_stall) begin
                samples_seen++;
                trace_sample(sample_item);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PIXEL_STEP:  step_cfg   = cfg_data[STEP_BITS-1:0];
                    REG_MIDDLE_LINE: middle_cfg = cfg_data[MIDDLE_BITS-1:0];
                    default: ;
                endcase
            end
        end
        endpoints_due = pending_endpoints.size();
    end

endmodule

[tb/waveform_minmax_decimator_test.sv]
`timescale 1ns / 100ps
// Top of the waveform min/max decimator testbench: clock, reset, sample stimulus,
// register settings and output backpressure. Depends on wmd_pkg, the block and
// waveform_minmax_decimator_checker.
module waveform_minmax_decimator_test;
    import wmd_pkg::*;

    localparam int RANDOM_ITEMS = 396;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
    typedef enum int {WAVE_SMOOTH, WAVE_NOISE, WAVE_RAIL} wave_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_item_t              sample_item = '0;
    logic                      point_valid;
    logic                      point_stall = 1'b0;
    point_item_t               point_item;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int fail_count;
    int endpoints_due;
    int samples_seen;
    int endpoints_seen;
    int cycle_count = 0;
    int burst_left = 0;
    int settings_applied = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_tick = 0;

    waveform_minmax_decimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_item   (point_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    waveform_minmax_decimator_checker endpoint_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample_item    (sample_item),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_item     (point_item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .endpoints_due  (endpoints_due),
        .samples_seen   (samples_seen),
        .endpoints_seen (endpoints_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("waveform_minmax_decimator regression: fail");
            $finish;
        end
    end

    // Receiver backpressure: switch between stall patterns every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  point_stall <= 1'b0;
            STALL_LIGHT: point_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: point_stall <= ($urandom_range(0, 99) < 75);
            default:     point_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input sample_t s, input logic first);
        if (burst_left == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample_item  <= {s, first};
        do @(posedge clk); while (sample_stall);
        @(negedge clk);
    endtask

    // Samples that change no column leave nothing to wait on, so pad with DRAIN_CYCLES
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (endpoints_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_registers(input logic [STEP_BITS-1:0] step,
                                 input logic [MIDDLE_BITS-1:0] middle);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PIXEL_STEP;
        cfg_data  <= CFG_DATA_BITS'(step);
        @(negedge clk);
        cfg_index <= REG_MIDDLE_LINE;
        cfg_data  <= CFG_DATA_BITS'(middle);
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        logic [STEP_BITS-1:0]   step;
        logic [MIDDLE_BITS-1:0] middle;
        wave_mode_t             wave;
        int                     random_sent;
        int                     buffer_left;
        int                     level;
        int                     run_len;
        logic                   first;

        random_sent = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings; the first sample arrives unprimed without a buffer start
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(16'h5555), 1'b1);
        send_sample(sample_t'(16'hAAAA), 1'b0);

        // Quarter-pixel step and tallest center: four samples fill a column
        set_registers(32'h0040_0000, 11'd2047);
        send_sample(sample_t'(0), 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(sample_t'(12345), 1'b0);
        send_sample(sample_t'(-12345), 1'b0);

        // Zero step never leaves column zero
        set_registers('0, '0);
        send_sample(sample_t'(100), 1'b1);
        send_sample(sample_t'(-200), 1'b0);
        send_sample(sample_t'(300), 1'b0);

        // Largest step: about 256 pixels per sample; x wraps only after 16 samples
        set_registers('1, 11'd1000);
        send_sample(SAMPLE_MIN, 1'b1);
        repeat (8) send_sample(sample_t'($urandom_range(0, 65535)), 1'b0);

        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: step = $urandom_range(32'h0008_0000, 32'h0200_0000);
                6, 7:             step = $urandom_range(32'h0200_0000, 32'h1000_0000);
                8:                step = $urandom();
                default:          step = PIXEL_STEP_RESET;
            endcase
            if ($urandom_range(0, 3) == 0)
                middle = $urandom_range(0, 1) ? '1 : '0;
            else
                middle = MIDDLE_BITS'($urandom_range(0, 2047));
            set_registers(step, middle);

            buffer_left = 0;
            level = 0;
            wave = WAVE_NOISE;
            run_len = $urandom_range(30, 70);
            if (run_len > RANDOM_ITEMS - random_sent)
                run_len = RANDOM_ITEMS - random_sent;
            repeat (run_len)
            begin
                if (buffer_left == 0)
                begin
                    buffer_left = $urandom_range(4, 40);
                    wave = wave_mode_t'($urandom_range(WAVE_SMOOTH, WAVE_RAIL));
                    level = int'($urandom_range(0, 65535)) - 32768;
                    first = 1'b1;
                end
                else
                    first = ($urandom_range(0, 19) == 0);   // stray restart mid-buffer
                case (wave)
                    WAVE_SMOOTH: level = level + int'($urandom_range(0, 4000)) - 2000;
                    WAVE_NOISE:  level = int'($urandom_range(0, 65535)) - 32768;
                    default:
                        case ($urandom_range(0, 3))
                            0:       level = int'(SAMPLE_MAX);
                            1:       level = int'(SAMPLE_MIN);
                            2:       level = int'($urandom_range(0, 2)) - 1;
                            default: level = int'($urandom_range(0, 65535)) - 32768;
                        endcase
                endcase
                if (level > int'(SAMPLE_MAX)) level = int'(SAMPLE_MAX);
                if (level < int'(SAMPLE_MIN)) level = int'(SAMPLE_MIN);
                send_sample(sample_t'(level), first);
                buffer_left--;
                random_sent++;
            end
        end

        sample_valid <= 1'b0;
        while (endpoints_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES * 2) @(negedge clk);

        $display("summary: %0d samples in, %0d endpoints checked", samples_seen,
                 endpoints_seen);
        $display("summary: %0d register settings, mismatches %0d", settings_applied,
                 fail_count);
        if (fail_count == 0 && endpoints_due == 0)
            $display("waveform_minmax_decimator regression: pass");
        else
            $display("waveform_minmax_decimator regression: fail");
        $finish;
    end

endmodule

[filelist.f]
design/wmd_pkg.sv
design/wmd_front.sv
design/wmd_queue.sv
design/wmd_back.sv
design/waveform_minmax_decimator.sv
tb/waveform_minmax_decimator_checker.sv
tb/waveform_minmax_decimator_test.sv
